>>> hdl/bf16sp_pkg.sv
// Shared types, fixed-point constants and multiply helpers for the bfloat16 sin(pi*x) pipeline.
// Depends on nothing; the top level uses it by scoped names.
package bf16sp_pkg;

    localparam int FRAC_BITS = 40;             // Q.40 fixed point throughout
    localparam int W         = 44;             // polynomial operand width
    localparam int HW        = W / 2;          // half width for partial products
    localparam int MW        = 51;             // magnitude width before rounding
    localparam int NSTG      = 13;             // pipeline depth

    // Coefficients in Q.40, magnitudes only; the signs are fixed by the range.
    localparam logic [W-1:0] C1L = 44'd3454217945668;
    localparam logic [W-1:0] C1  = 44'd3454132806817;
    localparam logic [W-1:0] C3  = 44'd5677943925702;
    localparam logic [W-1:0] C5  = 44'd2756389672299;
    localparam logic [W-1:0] C7  = 44'd487093018786;

    localparam logic [15:0] QNAN_INF = 16'h7FFF;
    localparam logic [15:0] INF_BITS = 16'h7F80;
    localparam logic [15:0] POS_ZERO = 16'h0000;
    localparam logic [14:0] LIN_MAX  = 15'd197;

    typedef struct packed {
        logic [2*HW-1:0] hh;
        logic [2*HW-1:0] hl;
        logic [2*HW-1:0] lh;
        logic [2*HW-1:0] ll;
    } pp_t;

    typedef struct packed {
        logic          spec;      // special operand, result already known
        logic [15:0]   spec_val;
        logic          sign;
        logic          lin;       // linear path
        logic [7:0]    z;         // binary point position of the linear product
        logic [W-1:0]  fx;        // fraction in Q.40
        logic [MW-1:0] lin_mag;
        logic [W-1:0]  x2;        // fx squared, Q.40
    } side_t;

    function automatic pp_t mul_pp(input logic [W-1:0] a, input logic [W-1:0] b);
        pp_t r;
        r.hh = a[W-1:HW] * b[W-1:HW];
        r.hl = a[W-1:HW] * b[HW-1:0];
        r.lh = a[HW-1:0] * b[W-1:HW];
        r.ll = a[HW-1:0] * b[HW-1:0];
        return r;
    endfunction

    // Sum the partial products and round half away from zero at FRAC_BITS.
    function automatic logic [W-1:0] mul_rnd(input pp_t p);
        logic [2*W-1:0] sum;
        sum = {p.hh, {(2*HW){1'b0}}}
            + ({{(2*HW){1'b0}}, p.hl} << HW)
            + ({{(2*HW){1'b0}}, p.lh} << HW)
            + {{(2*HW){1'b0}}, p.ll}
            + ({{(2*W-1){1'b0}}, 1'b1} << (FRAC_BITS - 1));
        return sum[FRAC_BITS +: W];
    endfunction

endpackage

>>> hdl/bfloat16_sinpi.sv
// Top level of the bfloat16 sin(pi*x) unit: decode, Horner polynomial, rounding.
// Depends on bf16sp_pkg for constants, types and the split multiply helpers.
//
//  Channel   Ports                          Payload
//  --------  -----------------------------  ------------------------------------
//  operand   s_tvalid s_tready s_tdata[15:0]  operand_bits (bfloat16)
//  result    m_tvalid m_tready m_tdata[15:0]  result_bits  (bfloat16 sin(pi*x))
//
// Thirteen register stages: one request enters per cycle when nothing stalls. Depth is
// set by the five Q.40 products of the polynomial, each split into four 22x22 partial
// products plus a summing stage.
// aresetn (synchronous, active low) clears every valid bit; payload is not reset.
// A stall on m_tready freezes the whole pipeline; s_tready drops with it.
module bfloat16_sinpi (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] operand_bits
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata     // [15:0] result_bits
);

    localparam int NSTG = bf16sp_pkg::NSTG;
    localparam int W    = bf16sp_pkg::W;
    localparam int MW   = bf16sp_pkg::MW;

    logic                 en;
    logic [NSTG-1:0]      vld_reg;
    bf16sp_pkg::side_t    sd_reg [NSTG];
    bf16sp_pkg::side_t    sd_next;
    bf16sp_pkg::side_t    sd2_next;
    bf16sp_pkg::pp_t      pp_reg [5];
    logic [W-1:0]         y1_reg;
    logic [W-1:0]         m2_reg;
    logic [W-1:0]         y3_reg;
    logic [MW-1:0]        mag10_reg;
    logic [7:0]           z10_reg;
    logic [MW-1:0]        mag11_reg;
    logic [5:0]           sh11_reg;
    logic signed [9:0]    bias11_reg;
    logic                 zero11_reg;
    logic [15:0]          res_reg;

    logic [5:0]           p_next;
    logic signed [9:0]    bias_next;
    logic [9:0]           sh_full;
    logic [14:0]          pack_next;

    // Advance everything unless the output holds an untaken result.
    assign en       = !vld_reg[NSTG-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NSTG-1];
    assign m_tdata  = res_reg;

    // Decode: specials, integer parity, fraction, mirror, path select.
    always_comb begin
        logic [14:0] mg;
        logic [7:0]  ex;
        logic [7:0]  mm;
        logic [7:0]  s;
        logic [7:0]  fn;
        logic [8:0]  fn9;
        logic [8:0]  hf;
        logic        odd;
        logic        neg;
        logic [15:0] lt;
        mg  = s_tdata[14:0];
        ex  = mg[14:7];
        mm  = (ex == 8'd0) ? {1'b0, mg[6:0]} : {1'b1, mg[6:0]};
        s   = 8'd134 - ((ex == 8'd0) ? 8'd1 : ex);
        neg = s_tdata[15] && (mg != 15'd0);
        odd = (s < 8'd8) ? mm[s[2:0]] : 1'b0;
        fn  = (s < 8'd8) ? (mm & ((8'd1 << s[2:0]) - 8'd1)) : mm;
        fn9 = {1'b0, fn};
        if (s >= 8'd1 && s <= 8'd8) begin
            hf = 9'd1 << (s[3:0] - 4'd1);
            if (fn9 >= hf)
                fn9 = (9'd1 << s[3:0]) - fn9;
        end else begin
            hf = 9'd0;
        end
        lt = {8'd0, fn9[7:0]} << (4'd15 - s[3:0]);

        sd_next.spec     = 1'b1;
        sd_next.spec_val = bf16sp_pkg::POS_ZERO;
        if (mg > bf16sp_pkg::INF_BITS[14:0])
            sd_next.spec_val = s_tdata;
        else if (mg == bf16sp_pkg::INF_BITS[14:0])
            sd_next.spec_val = bf16sp_pkg::QNAN_INF;
        else if (ex >= 8'd135)
            sd_next.spec_val = bf16sp_pkg::POS_ZERO;
        else
            sd_next.spec = 1'b0;
        sd_next.sign    = neg ^ odd;
        sd_next.lin     = (s >= 8'd16) || (lt[14:0] <= bf16sp_pkg::LIN_MAX && lt[15] == 1'b0);
        sd_next.z       = 8'd40 + s;
        sd_next.fx      = W'(({40'd0, fn9[7:0]} << bf16sp_pkg::FRAC_BITS) >> s);
        sd_next.lin_mag = MW'(bf16sp_pkg::C1L) * {{(MW-8){1'b0}}, fn9[7:0]};
        sd_next.x2      = '0;
    end

    // Stage two picks up fx squared.
    always_comb begin
        sd2_next    = sd_reg[1];
        sd2_next.x2 = bf16sp_pkg::mul_rnd(pp_reg[0]);
    end

    // Leading one of the final magnitude and the rounding shift.
    always_comb begin
        p_next = 6'd0;
        for (int i = 0; i < MW; i++) begin
            if (mag10_reg[i])
                p_next = 6'(i);
        end
        bias_next = $signed({4'd0, p_next}) - $signed({2'd0, z10_reg}) + 10'sd127;
        if (bias_next >= 10'sd1)
            sh_full = {4'd0, p_next} - 10'd7;
        else
            sh_full = {2'd0, z10_reg} - 10'd133;
    end

    // Round to nearest even and pack.
    always_comb begin
        logic [MW-1:0] mask;
        logic [MW-1:0] rem;
        logic [MW-1:0] half;
        logic [MW-1:0] kp;
        logic [9:0]    r;
        logic signed [9:0] b;
        kp   = mag11_reg >> sh11_reg;
        mask = ({{(MW-1){1'b0}}, 1'b1} << sh11_reg) - {{(MW-1){1'b0}}, 1'b1};
        rem  = mag11_reg & mask;
        half = {{(MW-1){1'b0}}, 1'b1} << (sh11_reg - 6'd1);
        r    = {1'b0, kp[8:0]};
        if (rem > half || (rem == half && kp[0]))
            r = r + 10'd1;
        b = bias11_reg;
        if (zero11_reg) begin
            pack_next = 15'd0;
        end else if (b < 10'sd1) begin
            pack_next = {5'd0, r};
        end else begin
            if (r[8]) begin
                r = r >> 1;
                b = b + 10'sd1;
            end
            if (b >= 10'sd255)
                pack_next = bf16sp_pkg::INF_BITS[14:0];
            else
                pack_next = {b[7:0], r[6:0]};
        end
    end

    // Valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NSTG-2:0], s_tvalid};
        end
    end

    // Datapath stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            sd_reg[0] <= sd_next;
            for (int k = 1; k < NSTG; k++)
                sd_reg[k] <= (k == 2) ? sd2_next : sd_reg[k-1];
            pp_reg[0]    <= bf16sp_pkg::mul_pp(sd_reg[0].fx, sd_reg[0].fx);
            pp_reg[1]    <= bf16sp_pkg::mul_pp(bf16sp_pkg::C7, sd_reg[2].x2);
            y1_reg       <= bf16sp_pkg::C5 - bf16sp_pkg::mul_rnd(pp_reg[1]);
            pp_reg[2]    <= bf16sp_pkg::mul_pp(y1_reg, sd_reg[4].x2);
            m2_reg       <= bf16sp_pkg::C3 - bf16sp_pkg::mul_rnd(pp_reg[2]);
            pp_reg[3]    <= bf16sp_pkg::mul_pp(m2_reg, sd_reg[6].x2);
            y3_reg       <= bf16sp_pkg::C1 - bf16sp_pkg::mul_rnd(pp_reg[3]);
            pp_reg[4]    <= bf16sp_pkg::mul_pp(y3_reg, sd_reg[8].fx);
            mag10_reg    <= sd_reg[9].lin ? sd_reg[9].lin_mag
                                          : MW'(bf16sp_pkg::mul_rnd(pp_reg[4]));
            z10_reg      <= sd_reg[9].lin ? sd_reg[9].z : 8'd40;
            mag11_reg    <= mag10_reg;
            sh11_reg     <= sh_full[5:0];
            bias11_reg   <= bias_next;
            zero11_reg   <= (mag10_reg == '0);
            res_reg      <= sd_reg[11].spec ? sd_reg[11].spec_val
                                            : {sd_reg[11].sign, pack_next};
        end
    end

    // Assertions.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    a_poly_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[10] && !sd_reg[10].spec && !sd_reg[10].lin |-> mag10_reg != '0)
        else $error("polynomial path gave zero magnitude");

    a_ready_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> !s_tready || !$past(s_tready))
        else $error("request taken while result held");

endmodule

>>> tb/bfloat16_sinpi_tb.sv
// Self-checking testbench for bfloat16_sinpi: directed table, then random requests.
// Depends on bf16sp_pkg (fixed-point coefficients) and the bfloat16_sinpi top level.
module bfloat16_sinpi_tb;

    localparam int N_RANDOM  = 550;
    localparam int LIMIT     = 400000;
    localparam int DRAIN     = 40;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;     // [15:0] operand_bits
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;     // [15:0] result_bits

    bfloat16_sinpi u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    typedef struct {
        logic [15:0] operand;
        bit          known;    // expected result typed in below
        logic [15:0] result;
    } vec_t;

    logic [15:0] sine_queue[$];
    int          errors = 0;
    int          cycles = 0;
    int          stall_mode = 0;

    // Q.40 signed product, magnitude rounded half away from zero.
    function automatic longint q40_mul(input longint a, input longint b);
        logic [127:0] prod;
        logic [63:0]  ua, ub, r;
        bit           neg;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? -a : a;
        ub   = (b < 0) ? -b : b;
        prod = {64'd0, ua} * {64'd0, ub};
        prod = prod + (128'd1 << (bf16sp_pkg::FRAC_BITS - 1));
        r    = prod[bf16sp_pkg::FRAC_BITS +: 64];
        r[63] = 1'b0;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    // Round mag * 2^-z to a bfloat16 magnitude, nearest even, subnormals kept.
    function automatic logic [14:0] round_bf16(input logic [63:0] mag, input int z);
        int          p, biased, sh;
        logic [63:0] keep, rem, half;
        if (mag == 0) return '0;
        p = 63;
        while (!mag[p]) p--;
        biased = p - z + 127;
        sh = (biased >= 1) ? p - 7 : z - 133;
        if (sh <= 0) begin
            keep = mag << (-sh);
        end else if (sh >= 64) begin
            keep = 0;
        end else begin
            keep = mag >> sh;
            rem  = mag & ((64'd1 << sh) - 1);
            half = 64'd1 << (sh - 1);
            if (rem > half || (rem == half && keep[0])) keep++;
        end
        if (biased < 1) return keep[14:0];
        if (keep >= 256) begin
            keep = keep >> 1;
            biased++;
        end
        if (biased >= 255) return bf16sp_pkg::INF_BITS[14:0];
        return {biased[7:0], keep[6:0]};
    endfunction

    function automatic logic [15:0] sinpi_of(input logic [15:0] x);
        logic [14:0] mag, res;
        int          e, m, s, ipart, fnum;
        bit          neg, sgn;
        longint      fx, x2, y;
        mag = x[14:0];
        if (mag > bf16sp_pkg::INF_BITS[14:0]) return x;
        if (mag == bf16sp_pkg::INF_BITS[14:0]) return bf16sp_pkg::QNAN_INF;
        e = mag[14:7];
        m = mag[6:0];
        if (e >= 135) return bf16sp_pkg::POS_ZERO;
        if (e == 0) e = 1;
        else m = m | 128;
        neg   = x[15] && mag != 0;
        s     = 134 - e;
        ipart = (s >= 8) ? 0 : (m >> s);
        fnum  = (s >= 8) ? m : (m & ((1 << s) - 1));
        if (s >= 1 && s <= 8 && fnum >= (1 << (s - 1))) fnum = (1 << s) - fnum;
        sgn = neg ^ ipart[0];
        if (s >= 16 || (fnum << (15 - s)) <= int'(bf16sp_pkg::LIN_MAX)) begin
            res = round_bf16(64'(bf16sp_pkg::C1L) * 64'(fnum), bf16sp_pkg::FRAC_BITS + s);
        end else begin
            fx = longint'(fnum) << (bf16sp_pkg::FRAC_BITS - s);
            x2 = q40_mul(fx, fx);
            y  = -longint'(bf16sp_pkg::C7);
            y  = q40_mul(y, x2) + longint'(bf16sp_pkg::C5);
            y  = q40_mul(y, x2) - longint'(bf16sp_pkg::C3);
            y  = q40_mul(y, x2) + longint'(bf16sp_pkg::C1);
            y  = q40_mul(y, fx);
            if (y < 0) y = 0;
            res = round_bf16(y, bf16sp_pkg::FRAC_BITS);
        end
        return {sgn, res};
    endfunction

    // Directed requests; expected values typed in only for the obvious ones.
    vec_t directed[] = '{
        '{16'h0000, 1, 16'h0000},   // +0
        '{16'h8000, 1, 16'h0000},   // -0 gives +0
        '{16'h7F80, 1, 16'h7FFF},   // +inf
        '{16'hFF80, 1, 16'h7FFF},   // -inf
        '{16'h7FC0, 1, 16'h7FC0},   // quiet NaN passes through
        '{16'hFF81, 1, 16'hFF81},   // negative NaN with payload
        '{16'h7FFF, 1, 16'h7FFF},
        '{16'h4380, 1, 16'h0000},   // exactly 256
        '{16'hC380, 1, 16'h0000},   // -256
        '{16'h7F7F, 1, 16'h0000},   // largest finite
        '{16'h3F80, 0, 16'h0000},   // 1.0, odd integer: -0
        '{16'hBF80, 0, 16'h0000},
        '{16'h4000, 0, 16'h0000},   // 2.0
        '{16'h3F00, 0, 16'h0000},   // one half
        '{16'hBF00, 0, 16'h0000},
        '{16'h3E80, 0, 16'h0000},   // quarter
        '{16'h3FC0, 0, 16'h0000},   // 1.5
        '{16'h3BC5, 0, 16'h0000},   // near the linear limit
        '{16'h3BC6, 0, 16'h0000},
        '{16'h0001, 0, 16'h0000},   // smallest subnormal
        '{16'h8001, 0, 16'h0000},
        '{16'h007F, 0, 16'h0000},   // largest subnormal
        '{16'h437F, 0, 16'h0000},   // just below 256
        '{16'hC37F, 0, 16'h0000},
        '{16'h3F7F, 0, 16'h0000}    // just below one
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: the stall pattern switches at random among four modes.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= ((cycles / 5) % 2 == 0);
        endcase
        if (cycles >= LIMIT) begin
            $display("FAIL bfloat16_sinpi");
            $finish;
        end
    end

    // Checker: compare each delivered result with the oldest prediction.
    always @(posedge aclk) begin
        logic [15:0] want;
        if (aresetn && m_tvalid && m_tready) begin
            if (sine_queue.size() == 0) begin
                $error("result_bits: nothing expected, actual %h", m_tdata);
                errors++;
            end else begin
                want = sine_queue.pop_front();
                if (m_tdata !== want) begin
                    $error("result_bits: expected %h actual %h", want, m_tdata);
                    errors++;
                end
            end
        end
    end

    // Hold the request until accepted; maybe drop tvalid for a gap after it.
    task automatic send(input logic [15:0] x, input int gap);
        s_tvalid <= 1'b1;
        s_tdata  <= x;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        sine_queue.push_back(sinpi_of(x));
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [15:0] random_operand();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 55)       // inside the working range, both paths
            return {1'($urandom), 8'($urandom_range(100, 134)), 7'($urandom)};
        else if (pick < 65)  // subnormals and tiny values
            return {1'($urandom), 8'($urandom_range(0, 8)), 7'($urandom)};
        else if (pick < 75)  // NaN, infinity, out of range
            return {1'($urandom), 8'($urandom_range(135, 255)), 7'($urandom)};
        else
            return 16'($urandom);
    endfunction

    initial begin
        int burst, gap;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) begin
            if (directed[i].known && sinpi_of(directed[i].operand) !== directed[i].result) begin
                $error("result_bits: table expects %h, predictor %h for %h",
                       directed[i].result, sinpi_of(directed[i].operand),
                       directed[i].operand);
                errors++;
            end
            send(directed[i].operand, (i % 4 == 3) ? 2 : 0);
        end

        // Random part: bursts of back-to-back requests with random gaps.
        burst = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            gap = 0;
            if (burst == 0) begin
                burst = $urandom_range(1, 30);
                gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            end
            burst--;
            send(random_operand(), gap);
        end
        s_tvalid <= 1'b0;

        while (sine_queue.size() != 0) @(posedge aclk);
        repeat (DRAIN) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS bfloat16_sinpi");
        end else begin
            $display("FAIL bfloat16_sinpi");
        end
        $finish;
    end

endmodule

>>> sim.f
hdl/bf16sp_pkg.sv
hdl/bfloat16_sinpi.sv
tb/bfloat16_sinpi_tb.sv
